### src/tlf_pkg.sv
// tlf_pkg: shared constants, types and codes for the text line folder
// no dependencies; used by every module of the block by scoped names

package tlf_pkg;

  localparam int MAX_WIDTH  = 16;
  localparam int LINE_DEPTH = MAX_WIDTH + 1;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CNT_W      = 5;
  localparam int FOLD_W     = 5;
  localparam int CHAR_W     = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [FOLD_W-1:0] FOLD_RESET = 5'd11;
  localparam logic [FOLD_W-1:0] FOLD_MIN   = 5'd2;
  localparam logic [FOLD_W-1:0] FOLD_MAX   = FOLD_W'(MAX_WIDTH);

  localparam logic [CHAR_W-1:0] CH_HYPHEN  = 8'd45;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

  // register index, taken from paddr bit 2
  localparam logic REG_FOLD_COLUMN = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_COPY
  } tlf_state_t;

  // one output word on its way: either a constant or the line memory read data
  typedef struct packed {
    logic              vld;
    logic              from_mem;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } tlf_issue_t;

endpackage

### src/tlf_line_ram.sv
// tlf_line_ram: line buffer memory, one write port and one registered read port
// depends on tlf_pkg

module tlf_line_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [tlf_pkg::ADDR_W-1:0] waddr,
  input  logic [tlf_pkg::CHAR_W-1:0] wdata,
  input  logic                      re,
  input  logic [tlf_pkg::ADDR_W-1:0] raddr,
  output logic [tlf_pkg::CHAR_W-1:0] rdata
);

  logic [tlf_pkg::CHAR_W-1:0] mem [tlf_pkg::LINE_DEPTH];
  logic [tlf_pkg::CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/tlf_out_buf.sv
// tlf_out_buf: read-data stage plus two-word output queue with issue credit
// depends on tlf_pkg

module tlf_out_buf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tlf_pkg::tlf_issue_t        issue,
  input  logic [tlf_pkg::CHAR_W-1:0] mem_rdata,
  output logic                       can_issue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tlf_pkg::CHAR_W-1:0] out_char,
  output logic                       out_last_of_run
);

  tlf_pkg::tlf_issue_t        stage_r;
  logic [tlf_pkg::CHAR_W-1:0] q_char_r [2];
  logic                       q_last_r [2];
  logic                       wr_ptr_r, wr_ptr_nxt;
  logic                       rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic [1:0]                 occ;
  logic                       push, pop;
  logic [tlf_pkg::CHAR_W-1:0] push_char;

  assign push      = stage_r.vld;
  assign pop       = out_valid && out_ready;
  assign push_char = stage_r.from_mem ? mem_rdata : stage_r.ch;
  // words queued plus word in the stage never exceed two
  assign occ       = cnt_r + {1'b0, stage_r.vld};
  assign can_issue = (occ <= 2'd1) || pop;

  assign wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
  assign cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      stage_r  <= issue;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_char_r[wr_ptr_r] <= push_char;
      q_last_r[wr_ptr_r] <= stage_r.last;
    end
  end

  assign out_valid       = cnt_r != 2'd0;
  assign out_char        = q_char_r[rd_ptr_r];
  assign out_last_of_run = q_last_r[rd_ptr_r];

endmodule

### src/tlf_seq.sv
// tlf_seq: line state registers and the emit / copy sequencer around the line memory
// depends on tlf_pkg

module tlf_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [tlf_pkg::FOLD_W-1:0] fold_column,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tlf_pkg::CHAR_W-1:0] in_char,
  input  logic                       can_issue,
  output tlf_pkg::tlf_issue_t        issue,
  output logic                       mem_we,
  output logic [tlf_pkg::ADDR_W-1:0] mem_waddr,
  output logic [tlf_pkg::CHAR_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [tlf_pkg::ADDR_W-1:0] mem_raddr,
  input  logic [tlf_pkg::CHAR_W-1:0] mem_rdata
);

  tlf_pkg::tlf_state_t       state_r, state_nxt;

  logic [tlf_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [tlf_pkg::CNT_W-1:0] run_start_r, run_start_nxt;
  logic [tlf_pkg::CNT_W-1:0] run_end_r, run_end_nxt;
  logic                      seen_r, seen_nxt;

  logic [tlf_pkg::CNT_W-1:0] emit_cnt_r, emit_cnt_nxt;
  logic                      hyph_r, hyph_nxt;
  logic [tlf_pkg::CNT_W-1:0] copy_base_r, copy_base_nxt;
  logic [tlf_pkg::CNT_W-1:0] copy_cnt_r, copy_cnt_nxt;
  logic [tlf_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic                      cp_pend_r, cp_pend_nxt;
  logic [tlf_pkg::ADDR_W-1:0] cp_dst_r, cp_dst_nxt;

  logic [tlf_pkg::FOLD_W-1:0] limit;
  logic [tlf_pkg::CNT_W-1:0]  col;
  logic                       accept, is_nl, is_blank, at_fold, run_ok, has_out;
  logic                       emit_more, copy_last;

  assign limit = (fold_column < tlf_pkg::FOLD_MIN) ? tlf_pkg::FOLD_MIN :
                 (fold_column > tlf_pkg::FOLD_MAX) ? tlf_pkg::FOLD_MAX : fold_column;
  assign col   = (fill_r > tlf_pkg::CNT_W'(tlf_pkg::MAX_WIDTH)) ?
                 tlf_pkg::CNT_W'(tlf_pkg::MAX_WIDTH) : fill_r;

  assign in_ready  = (state_r == tlf_pkg::ST_IDLE) && !cp_pend_r;
  assign accept    = in_valid && in_ready;
  assign is_nl     = in_char == tlf_pkg::CH_NEWLINE;
  assign is_blank  = (in_char == tlf_pkg::CH_SPACE) || (in_char == tlf_pkg::CH_TAB);
  assign at_fold   = col >= limit;
  assign run_ok    = seen_r && (run_end_r < col) && (run_start_r <= run_end_r);
  assign has_out   = is_nl || at_fold;
  assign emit_more = idx_r < emit_cnt_r;
  assign copy_last = idx_r == (copy_cnt_r - 5'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlf_pkg::ST_IDLE: begin
        if (accept && has_out) begin
          state_nxt = tlf_pkg::ST_EMIT;
        end
      end
      tlf_pkg::ST_EMIT: begin
        if (can_issue && !emit_more && !hyph_r) begin
          state_nxt = (copy_cnt_r != '0) ? tlf_pkg::ST_COPY : tlf_pkg::ST_IDLE;
        end
      end
      tlf_pkg::ST_COPY: begin
        if (copy_last) begin
          state_nxt = tlf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tlf_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    issue         = '0;
    mem_re        = 1'b0;
    mem_raddr     = idx_r;
    mem_we        = 1'b0;
    mem_waddr     = col;
    mem_wdata     = in_char;
    fill_nxt      = fill_r;
    run_start_nxt = run_start_r;
    run_end_nxt   = run_end_r;
    seen_nxt      = seen_r;
    emit_cnt_nxt  = emit_cnt_r;
    hyph_nxt      = hyph_r;
    copy_base_nxt = copy_base_r;
    copy_cnt_nxt  = copy_cnt_r;
    idx_nxt       = idx_r;
    cp_pend_nxt   = 1'b0;
    cp_dst_nxt    = cp_dst_r;

    // pending copy write, in the cycle after its read
    if (cp_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = cp_dst_r;
      mem_wdata = mem_rdata;
    end

    case (state_r)
      tlf_pkg::ST_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          if (is_nl) begin
            emit_cnt_nxt = col;
            hyph_nxt     = 1'b0;
            copy_cnt_nxt = '0;
            fill_nxt     = '0;
            seen_nxt     = 1'b0;
          end else begin
            mem_we   = 1'b1;
            fill_nxt = col + 5'd1;
            if (at_fold) begin
              seen_nxt = 1'b0;
              if (is_blank) begin
                emit_cnt_nxt = col;
                hyph_nxt     = 1'b0;
                copy_cnt_nxt = '0;
                fill_nxt     = '0;
              end else if (run_ok) begin
                emit_cnt_nxt  = run_start_r;
                hyph_nxt      = 1'b0;
                copy_base_nxt = run_end_r + 5'd1;
                copy_cnt_nxt  = col - run_end_r;
                fill_nxt      = col - run_end_r;
              end else begin
                // hyphen break keeps the last buffered char and the new one
                emit_cnt_nxt  = col - 5'd1;
                hyph_nxt      = 1'b1;
                copy_base_nxt = col - 5'd1;
                copy_cnt_nxt  = 5'd2;
                fill_nxt      = 5'd2;
              end
            end else if (is_blank) begin
              if (!seen_r || ((run_end_r + 5'd1) != col)) begin
                run_start_nxt = col;
              end
              run_end_nxt = col;
              seen_nxt    = 1'b1;
            end
          end
        end
      end
      tlf_pkg::ST_EMIT: begin
        if (can_issue) begin
          if (emit_more) begin
            mem_re         = 1'b1;
            mem_raddr      = tlf_pkg::ADDR_W'(idx_r);
            issue.vld      = 1'b1;
            issue.from_mem = 1'b1;
            idx_nxt        = idx_r + 5'd1;
          end else if (hyph_r) begin
            issue.vld = 1'b1;
            issue.ch  = tlf_pkg::CH_HYPHEN;
            hyph_nxt  = 1'b0;
          end else begin
            issue.vld  = 1'b1;
            issue.ch   = tlf_pkg::CH_NEWLINE;
            issue.last = 1'b1;
            idx_nxt    = '0;
          end
        end
      end
      tlf_pkg::ST_COPY: begin
        mem_re      = 1'b1;
        mem_raddr   = tlf_pkg::ADDR_W'(copy_base_r + idx_r);
        cp_pend_nxt = 1'b1;
        cp_dst_nxt  = tlf_pkg::ADDR_W'(idx_r);
        idx_nxt     = copy_last ? '0 : idx_r + 5'd1;
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlf_pkg::ST_IDLE;
      fill_r      <= '0;
      run_start_r <= '0;
      run_end_r   <= '0;
      seen_r      <= 1'b0;
      hyph_r      <= 1'b0;
      idx_r       <= '0;
      cp_pend_r   <= 1'b0;
      emit_cnt_r  <= '0;
      copy_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      run_start_r <= run_start_nxt;
      run_end_r   <= run_end_nxt;
      seen_r      <= seen_nxt;
      hyph_r      <= hyph_nxt;
      idx_r       <= idx_nxt;
      cp_pend_r   <= cp_pend_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      copy_cnt_r  <= copy_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    copy_base_r <= copy_base_nxt;
    cp_dst_r    <= cp_dst_nxt;
  end

endmodule

### src/text_line_folder.sv
// text_line_folder: greedy word wrap of a byte stream at a programmable fold column
// output path: an accepted newline or fold starts the emit pass; its words go through the
//   read-data stage and the output queue. Input flow: a char that folds nothing keeps input
//   open; a fold or newline closes it for the emit pass, and for the copy pass when a word is
//   carried over, as the single read port of the line memory serves both passes
// reset: rst_n synchronous active low clears control and fold_column (11); line memory keeps data

module text_line_folder (
  input  logic                          clk,
  input  logic                          rst_n,
  // input word channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tlf_pkg::CHAR_W-1:0]    in_char,
  // result word channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tlf_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last_of_run,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tlf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tlf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [tlf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);

  logic [tlf_pkg::FOLD_W-1:0] fold_column_r, fold_column_nxt;
  logic                       cfg_wr, cfg_hit;

  tlf_pkg::tlf_issue_t        issue;
  logic                       can_issue;
  logic                       mem_we, mem_re;
  logic [tlf_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [tlf_pkg::CHAR_W-1:0] mem_wdata, mem_rdata;

  // apb slave: no wait states, one register at byte address 0, decoded from paddr bit 2 only
  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[2] == tlf_pkg::REG_FOLD_COLUMN;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // only the low five bits of the written word are kept
  assign fold_column_nxt = (cfg_wr && cfg_hit) ? cfg_pwdata[tlf_pkg::FOLD_W-1:0]
                                               : fold_column_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_column_r <= tlf_pkg::FOLD_RESET;
    end else begin
      fold_column_r <= fold_column_nxt;
    end
  end

  // reads with paddr bit 2 set return zero
  assign cfg_prdata = cfg_hit ? {{(tlf_pkg::CFG_DATA_W - tlf_pkg::FOLD_W){1'b0}}, fold_column_r}
                              : '0;

  // sequencer: owns fill count and blank-run marks, drives the emit and copy passes
  tlf_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .fold_column (fold_column_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char     (in_char),
    .can_issue   (can_issue),
    .issue       (issue),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  // line buffer, 17 chars, registered read data in the cycle after the address
  tlf_line_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // read-data stage and two-word queue; the credit back to the sequencer
  // keeps the queue from overflowing while the consumer stalls
  tlf_out_buf u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .issue           (issue),
    .mem_rdata       (mem_rdata),
    .can_issue       (can_issue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

endmodule

### src/tlf_checker.sv
// tlf_checker: port-level assertions for the text line folder, bound to the top level
// depends on tlf_pkg and text_line_folder

module tlf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [tlf_pkg::CHAR_W-1:0] in_char,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tlf_pkg::CHAR_W-1:0] out_char,
  input logic                       out_last_of_run
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last_of_run))
    else $error("output word changed while stalled");

  // every run of results closes with a newline
  a_last_is_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> out_char == tlf_pkg::CH_NEWLINE)
    else $error("last word of a run is not a newline");

  // a newline always starts an emit pass, so input closes
  a_nl_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_char == tlf_pkg::CH_NEWLINE |=> !in_ready)
    else $error("input still open after a newline");

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind text_line_folder tlf_checker u_tlf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_char         (in_char),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_char        (out_char),
  .out_last_of_run (out_last_of_run)
);
